// ===== hw/rtl/lrqs_pkg.sv =====
// Shared constants, codes and the ticket window lookup of the lottery ready-queue scheduler.
package lrqs_pkg;

  // Field widths of the channels.
  localparam int MODE_W   = 2;
  localparam int TASK_W   = 4;
  localparam int LEVEL_W  = 3;
  localparam int COUNT_W  = 32;
  localparam int STATUS_W = 3;

  // Default task count and fixed number of ready queues.
  localparam int NUM_TASKS_DEF = 16;
  localparam int NUM_LEVELS    = 5;
  localparam int LIDX_W        = $clog2(NUM_LEVELS);

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADLVL = 3'd4;

  // Residue unit: the count is reduced one byte per step.
  localparam int TICKETS     = 72;
  localparam int RES_W       = 7;
  localparam int DIGIT_W     = 8;
  localparam int DIGITS      = COUNT_W / DIGIT_W;
  localparam int STEP_W      = $clog2(DIGITS);
  localparam int V_W         = RES_W + DIGIT_W;
  localparam int RECIP       = 910;
  localparam int RECIP_W     = 10;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = V_W + RECIP_W;
  localparam int EST_W       = PROD_W - RECIP_SHIFT;

  // Ticket windows, inclusive bounds.
  localparam logic [RES_W-1:0] W1_LO = 7'd1;
  localparam logic [RES_W-1:0] W1_HI = 7'd10;
  localparam logic [RES_W-1:0] W2_LO = 7'd12;
  localparam logic [RES_W-1:0] W2_HI = 7'd22;
  localparam logic [RES_W-1:0] W3_LO = 7'd24;
  localparam logic [RES_W-1:0] W3_HI = 7'd36;
  localparam logic [RES_W-1:0] W4_LO = 7'd38;
  localparam logic [RES_W-1:0] W4_HI = 7'd52;
  localparam logic [RES_W-1:0] W5_LO = 7'd54;
  localparam logic [RES_W-1:0] W5_HI = 7'd71;

  // Level picked by a draw, zero when the draw falls between windows.
  function automatic logic [LEVEL_W-1:0] ticket_level(input logic [RES_W-1:0] r);
    logic [LEVEL_W-1:0] lvl;
    lvl = 3'd0;
    if (r >= W1_LO && r <= W1_HI) lvl = 3'd1;
    if (r >= W2_LO && r <= W2_HI) lvl = 3'd2;
    if (r >= W3_LO && r <= W3_HI) lvl = 3'd3;
    if (r >= W4_LO && r <= W4_HI) lvl = 3'd4;
    if (r >= W5_LO && r <= W5_HI) lvl = 3'd5;
    return lvl;
  endfunction

endpackage

// ===== hw/rtl/lrqs_in_if.sv =====
// Request channel of the scheduler: valid, ready and one operation item.
interface lrqs_in_if;
  logic                          valid;
  logic                          ready;
  logic [lrqs_pkg::MODE_W-1:0]   mode;
  logic [lrqs_pkg::TASK_W-1:0]   task_id;
  logic [lrqs_pkg::LEVEL_W-1:0]  level;
  logic [lrqs_pkg::COUNT_W-1:0]  random_count;

  modport source (output valid, mode, task_id, level, random_count, input ready);
  modport sink (input valid, mode, task_id, level, random_count, output ready);
endinterface

// ===== hw/rtl/lrqs_out_if.sv =====
// Result channel of the scheduler: valid, ready and one result item.
interface lrqs_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrqs_pkg::STATUS_W-1:0] status;
  logic [lrqs_pkg::TASK_W-1:0]   chosen_task;
  logic                          found;
  logic                          successor_valid;
  logic [lrqs_pkg::TASK_W-1:0]   successor_task;
  logic [lrqs_pkg::NUM_LEVELS-1:0] nonempty_mask;

  modport source (output valid, status, chosen_task, found, successor_valid,
                  successor_task, nonempty_mask, input ready);
  modport sink (input valid, status, chosen_task, found, successor_valid,
                successor_task, nonempty_mask, output ready);
endinterface

// ===== hw/rtl/lrqs_mod72.sv =====
// Iterative residue unit: reduces the 32-bit draw count modulo 72, one byte per cycle.
module lrqs_mod72 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lrqs_pkg::COUNT_W-1:0]  value,
  output logic                          done,
  output logic [lrqs_pkg::RES_W-1:0]    residue
);

  logic [lrqs_pkg::COUNT_W-1:0] digits_r;
  logic [lrqs_pkg::RES_W-1:0]   res_r;
  logic [lrqs_pkg::RES_W-1:0]   res_nxt;
  logic [lrqs_pkg::STEP_W-1:0]  step_r;
  logic                         busy_r;
  logic                         done_r;

  logic [lrqs_pkg::V_W-1:0]     v;
  logic [lrqs_pkg::PROD_W-1:0]  prod;
  logic [lrqs_pkg::EST_W-1:0]   est;
  logic [lrqs_pkg::V_W-1:0]     est72;
  logic [lrqs_pkg::V_W-1:0]     diff;
  logic [lrqs_pkg::V_W-1:0]     diff_fix;

  // One step: v = r * 256 + next byte, quotient estimated through a reciprocal.
  // The estimate is the true quotient or one less, so one correction follows.
  always_comb begin
    v        = {res_r, digits_r[lrqs_pkg::COUNT_W-1 -: lrqs_pkg::DIGIT_W]};
    prod     = lrqs_pkg::PROD_W'(v) * lrqs_pkg::PROD_W'(lrqs_pkg::RECIP);
    est      = prod[lrqs_pkg::PROD_W-1 -: lrqs_pkg::EST_W];
    est72    = lrqs_pkg::V_W'({est, 6'b0}) + lrqs_pkg::V_W'({est, 3'b0});
    diff     = v - est72;
    diff_fix = (diff >= lrqs_pkg::V_W'(lrqs_pkg::TICKETS)) ?
               diff - lrqs_pkg::V_W'(lrqs_pkg::TICKETS) : diff;
    res_nxt  = diff_fix[lrqs_pkg::RES_W-1:0];
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == lrqs_pkg::STEP_W'(lrqs_pkg::DIGITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      digits_r <= value;
      res_r    <= '0;
    end else if (busy_r) begin
      digits_r <= digits_r << lrqs_pkg::DIGIT_W;
      res_r    <= res_nxt;
    end
  end

  assign done    = done_r;
  assign residue = res_r;

endmodule

// ===== hw/rtl/lottery_ready_queue_scheduler.sv =====
// Lottery ready-queue scheduler: five FIFO ready queues of task ids kept as linked lists.
//
// Usage: requests arrive on in_ch (valid/ready) with a mode, a task id, a level 1 to 5
// and a sampled free-running count. Push appends a task to a level, lottery dequeue
// reduces the count modulo 72, maps it through fixed ticket windows to a level and
// pops its head, remove unlinks a task from anywhere in a level and returns its
// successor, and query reports whether a task sits in a level. Every item produces
// exactly one result item on out_ch, which also carries the nonempty mask after the
// operation. One item is in work at a time; in_ch.ready is high only while idle.
// Push, remove and query read the stores at the accepting edge and update from S_LOOK
// once the output register is free; the result is registered at that update.
// Lottery dequeue reduces the count in the residue unit one byte per step, sees it done
// in S_DRAW, does the window and head lookup with the link read of the head's successor
// in S_WIN and the update in S_POP, which registers the result. A draw that misses
// finishes from S_WIN and skips S_POP.
// Results sit in an output register; while the receiver stalls, the next item is
// still accepted and worked, and its update waits until the output slot frees.
// Reset empties all queues at once through per-task queued flags and per-level
// nonempty flags; the link stores themselves need no clearing.
module lottery_ready_queue_scheduler #(
  parameter int NUM_TASKS = lrqs_pkg::NUM_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lrqs_in_if.sink     in_ch,
  lrqs_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int TW    = lrqs_pkg::TASK_W;
  localparam int LW    = lrqs_pkg::LEVEL_W;
  localparam int NL    = lrqs_pkg::NUM_LEVELS;
  localparam int QW    = lrqs_pkg::LIDX_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_DRAW = 3'd2;
  localparam logic [2:0] S_WIN  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Latched request.
  logic [lrqs_pkg::MODE_W-1:0] mode_r;
  logic [TW-1:0]               task_r;
  logic [LW-1:0]               level_r;
  logic [TW-1:0]               pop_r, pop_nxt;

  // Queue ends and flags.
  logic [TW-1:0]        head_r [NL];
  logic [TW-1:0]        tail_r [NL];
  logic [TW-1:0]        head_nxt [NL];
  logic [TW-1:0]        tail_nxt [NL];
  logic [NL-1:0]        nonempty_r, nonempty_nxt;
  logic [NUM_TASKS-1:0] queued_r, queued_nxt;

  // Link and level stores.
  logic [TW-1:0] next_mem [NUM_TASKS];
  logic [TW-1:0] prev_mem [NUM_TASKS];
  logic [LW-1:0] lvl_mem  [NUM_TASKS];
  logic [TW-1:0] next_rd_r, prev_rd_r;
  logic [LW-1:0] lvl_rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic             nx_we, pv_we, lv_we;
  logic [IDX_W-1:0] nx_wa, pv_wa, lv_wa;
  logic [TW-1:0]    nx_wd, pv_wd;
  logic [LW-1:0]    lv_wd;

  // Output register.
  logic                          out_valid_r;
  logic [lrqs_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [TW-1:0]                 chosen_r, chosen_nxt;
  logic                          found_r, found_nxt;
  logic                          sv_r, sv_nxt;
  logic [TW-1:0]                 st_r, st_nxt;
  logic [NL-1:0]                 mask_r;
  logic                          finish;

  // Residue unit.
  logic                       in_fire;
  logic                       mod_start;
  logic                       mod_done;
  logic [lrqs_pkg::RES_W-1:0] residue;

  // Decoded request fields.
  logic             lvl_ok, t_ok, can_finish;
  logic [QW-1:0]    lvl_q, win_q, sel_q;
  logic [LW-1:0]    win_lvl;
  logic [IDX_W-1:0] t_idx;
  logic [TW-1:0]    head_sel, tail_sel;
  logic             at_head, at_tail;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign mod_start = in_fire && (in_ch.mode == lrqs_pkg::MODE_DEQ);

  lrqs_mod72 u_mod72 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .value   (in_ch.random_count),
    .done    (mod_done),
    .residue (residue)
  );

  // Request decode and queue selection.
  always_comb begin
    lvl_ok     = (level_r >= LW'(1)) && (level_r <= LW'(NL));
    t_ok       = (int'(task_r) < NUM_TASKS);
    t_idx      = IDX_W'(task_r);
    lvl_q      = QW'(level_r - LW'(1));
    win_lvl    = lrqs_pkg::ticket_level(residue);
    win_q      = QW'(win_lvl - LW'(1));
    sel_q      = (state_r == S_WIN || state_r == S_POP) ? win_q : lvl_q;
    head_sel   = head_r[sel_q];
    tail_sel   = tail_r[sel_q];
    at_head    = (head_sel == task_r);
    at_tail    = (tail_sel == task_r);
    can_finish = !out_valid_r || out_ch.ready;
  end

  // Store read address: the request's task, then the chosen head for a dequeue.
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = IDX_W'(in_ch.task_id);
      S_WIN:   rd_addr = IDX_W'(head_sel);
      S_POP:   rd_addr = IDX_W'(pop_r);
      default: rd_addr = t_idx;
    endcase
  end

  // Sequencer and queue update.
  always_comb begin
    state_nxt    = state_r;
    pop_nxt      = pop_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    queued_nxt   = queued_r;
    nx_we = 1'b0;  nx_wa = t_idx;  nx_wd = task_r;
    pv_we = 1'b0;  pv_wa = t_idx;  pv_wd = tail_sel;
    lv_we = 1'b0;  lv_wa = t_idx;  lv_wd = level_r;
    finish     = 1'b0;
    status_nxt = lrqs_pkg::ST_OK;
    chosen_nxt = '0;
    found_nxt  = 1'b0;
    sv_nxt     = 1'b0;
    st_nxt     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.mode == lrqs_pkg::MODE_DEQ) ? S_DRAW : S_LOOK;
        end
      end

      S_LOOK: begin
        if (can_finish) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
          case (mode_r)
            lrqs_pkg::MODE_PUSH: begin
              if (!lvl_ok) begin
                status_nxt = lrqs_pkg::ST_BADLVL;
              end else if (!t_ok) begin
                status_nxt = lrqs_pkg::ST_ABSENT;
              end else if (queued_r[t_idx]) begin
                status_nxt = lrqs_pkg::ST_DUP;
              end else begin
                // Append at the tail; the old tail gains a forward link.
                if (nonempty_r[sel_q]) begin
                  nx_we = 1'b1;
                  nx_wa = IDX_W'(tail_sel);
                  nx_wd = task_r;
                end else begin
                  head_nxt[sel_q] = task_r;
                end
                pv_we = 1'b1;
                pv_wd = tail_sel;
                lv_we = 1'b1;
                tail_nxt[sel_q]     = task_r;
                nonempty_nxt[sel_q] = 1'b1;
                queued_nxt[t_idx]   = 1'b1;
              end
            end
            lrqs_pkg::MODE_REMOVE: begin
              if (!lvl_ok) begin
                status_nxt = lrqs_pkg::ST_BADLVL;
              end else if (!t_ok || !queued_r[t_idx] || lvl_rd_r != level_r) begin
                status_nxt = lrqs_pkg::ST_ABSENT;
              end else begin
                sv_nxt = !at_tail;
                st_nxt = at_tail ? '0 : next_rd_r;
                // Unlink from wherever the task sits in its list.
                if (at_head && at_tail) begin
                  nonempty_nxt[sel_q] = 1'b0;
                end else if (at_head) begin
                  head_nxt[sel_q] = next_rd_r;
                end else if (at_tail) begin
                  tail_nxt[sel_q] = prev_rd_r;
                end else begin
                  nx_we = 1'b1;
                  nx_wa = IDX_W'(prev_rd_r);
                  nx_wd = next_rd_r;
                  pv_we = 1'b1;
                  pv_wa = IDX_W'(next_rd_r);
                  pv_wd = prev_rd_r;
                end
                queued_nxt[t_idx] = 1'b0;
              end
            end
            default: begin
              // Membership query.
              if (!lvl_ok) begin
                status_nxt = lrqs_pkg::ST_BADLVL;
              end else begin
                found_nxt = t_ok && queued_r[t_idx] && (lvl_rd_r == level_r);
              end
            end
          endcase
        end
      end

      S_DRAW: begin
        if (mod_done) begin
          state_nxt = S_WIN;
        end
      end

      S_WIN: begin
        // A draw between windows or into an empty queue is a miss.
        if (win_lvl == '0 || !nonempty_r[win_q]) begin
          if (can_finish) begin
            finish     = 1'b1;
            status_nxt = lrqs_pkg::ST_MISS;
            state_nxt  = S_IDLE;
          end
        end else begin
          pop_nxt   = head_sel;
          state_nxt = S_POP;
        end
      end

      S_POP: begin
        if (can_finish) begin
          finish     = 1'b1;
          chosen_nxt = pop_r;
          state_nxt  = S_IDLE;
          if (tail_sel == pop_r) begin
            nonempty_nxt[sel_q] = 1'b0;
          end else begin
            head_nxt[sel_q] = next_rd_r;
          end
          queued_nxt[IDX_W'(pop_r)] = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nonempty_r  <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      nonempty_r <= nonempty_nxt;
      queued_r   <= queued_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= in_ch.mode;
      task_r  <= in_ch.task_id;
      level_r <= in_ch.level;
    end
    pop_r    <= pop_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    if (finish) begin
      status_r <= status_nxt;
      chosen_r <= chosen_nxt;
      found_r  <= found_nxt;
      sv_r     <= sv_nxt;
      st_r     <= st_nxt;
      mask_r   <= nonempty_nxt;
    end
  end

  // Link and level stores: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (lv_we) lvl_mem[lv_wa]  <= lv_wd;
    next_rd_r <= next_mem[rd_addr];
    prev_rd_r <= prev_mem[rd_addr];
    lvl_rd_r  <= lvl_mem[rd_addr];
  end

  // Channel outputs.
  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.chosen_task     = chosen_r;
  assign out_ch.found           = found_r;
  assign out_ch.successor_valid = sv_r;
  assign out_ch.successor_task  = st_r;
  assign out_ch.nonempty_mask   = mask_r;

endmodule

// ===== verif/lottery_ready_queue_scheduler_tb.sv =====
// Self-checking testbench of the lottery ready-queue scheduler.
`timescale 1ns / 1ps

module lottery_ready_queue_scheduler_tb;

  localparam int NTASK = lrqs_pkg::NUM_TASKS_DEF;

  // One request item and one result item as the channels carry them.
  typedef struct {
    logic [lrqs_pkg::MODE_W-1:0]  mode;
    logic [lrqs_pkg::TASK_W-1:0]  tid;
    logic [lrqs_pkg::LEVEL_W-1:0] level;
    logic [lrqs_pkg::COUNT_W-1:0] random_count;
  } sched_req_t;

  typedef struct {
    logic [lrqs_pkg::STATUS_W-1:0]   status;
    logic [lrqs_pkg::TASK_W-1:0]     chosen_task;
    logic                            found;
    logic                            successor_valid;
    logic [lrqs_pkg::TASK_W-1:0]     successor_task;
    logic [lrqs_pkg::NUM_LEVELS-1:0] nonempty_mask;
  } sched_res_t;

  // Tracks the ready queues as plain FIFOs and holds the results still owed.
  class ready_queue_tracker_t;
    logic [lrqs_pkg::LEVEL_W-1:0] level_of [NTASK];
    logic [lrqs_pkg::TASK_W-1:0]  ready_q [lrqs_pkg::NUM_LEVELS][$];
    sched_res_t                   owed_results [$];
    int unsigned                  errors;

    function new();
      foreach (level_of[i]) level_of[i] = '0;
      errors = 0;
    endfunction

    // Level whose ticket window holds the residue, zero between windows.
    function int unsigned window_of(logic [lrqs_pkg::COUNT_W-1:0] cnt);
      int unsigned draw;
      draw = int'(cnt % 32'(lrqs_pkg::TICKETS));
      if (draw == 0 || draw == 11 || draw == 23 || draw == 37 || draw == 53) return 0;
      if (draw < 11) return 1;
      if (draw < 23) return 2;
      if (draw < 37) return 3;
      if (draw < 53) return 4;
      return 5;
    endfunction

    function sched_res_t predict(sched_req_t r);
      sched_res_t res;
      bit lvl_ok;
      int q;
      int pos;
      int unsigned w;
      res = '{default: '0};
      res.status = lrqs_pkg::ST_OK;
      lvl_ok = (r.level >= 1) && (r.level <= lrqs_pkg::NUM_LEVELS);
      q = int'(r.level) - 1;
      case (r.mode)
        lrqs_pkg::MODE_PUSH: begin
          if (!lvl_ok) begin
            res.status = lrqs_pkg::ST_BADLVL;
          end else if (level_of[r.tid] != 0) begin
            res.status = lrqs_pkg::ST_DUP;
          end else begin
            ready_q[q].push_back(r.tid);
            level_of[r.tid] = r.level;
          end
        end
        lrqs_pkg::MODE_DEQ: begin
          w = window_of(r.random_count);
          if (w == 0 || ready_q[w-1].size() == 0) begin
            res.status = lrqs_pkg::ST_MISS;
          end else begin
            res.chosen_task = ready_q[w-1].pop_front();
            level_of[res.chosen_task] = '0;
          end
        end
        lrqs_pkg::MODE_REMOVE: begin
          if (!lvl_ok) begin
            res.status = lrqs_pkg::ST_BADLVL;
          end else if (level_of[r.tid] != r.level) begin
            res.status = lrqs_pkg::ST_ABSENT;
          end else begin
            pos = 0;
            for (int i = 0; i < ready_q[q].size(); i++)
              if (ready_q[q][i] == r.tid) pos = i;
            if (pos < ready_q[q].size() - 1) begin
              res.successor_valid = 1'b1;
              res.successor_task = ready_q[q][pos+1];
            end
            ready_q[q].delete(pos);
            level_of[r.tid] = '0;
          end
        end
        default: begin
          if (!lvl_ok) res.status = lrqs_pkg::ST_BADLVL;
          else res.found = (level_of[r.tid] == r.level);
        end
      endcase
      for (int l = 0; l < lrqs_pkg::NUM_LEVELS; l++)
        res.nonempty_mask[l] = (ready_q[l].size() != 0);
      return res;
    endfunction

    function void note_request(sched_req_t r);
      owed_results.push_back(predict(r));
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    task check_result(sched_res_t got);
      sched_res_t exp;
      if (owed_results.size() == 0) begin
        report_mismatch("result item arrived with nothing expected");
      end else begin
        exp = owed_results.pop_front();
        if (got.status !== exp.status)
          report_mismatch($sformatf("status exp %0d got %0d", exp.status, got.status));
        if (got.chosen_task !== exp.chosen_task)
          report_mismatch($sformatf("chosen_task exp %0d got %0d",
                                    exp.chosen_task, got.chosen_task));
        if (got.found !== exp.found)
          report_mismatch($sformatf("found exp %0b got %0b", exp.found, got.found));
        if (got.successor_valid !== exp.successor_valid)
          report_mismatch($sformatf("successor_valid exp %0b got %0b",
                                    exp.successor_valid, got.successor_valid));
        if (got.successor_task !== exp.successor_task)
          report_mismatch($sformatf("successor_task exp %0d got %0d",
                                    exp.successor_task, got.successor_task));
        if (got.nonempty_mask !== exp.nonempty_mask)
          report_mismatch($sformatf("nonempty_mask exp %05b got %05b",
                                    exp.nonempty_mask, got.nonempty_mask));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int unsigned rx_cycle;
  int unsigned hold_left;
  ready_queue_tracker_t tracker;

  lrqs_in_if  in_ch ();
  lrqs_out_if out_ch ();

  lottery_ready_queue_scheduler u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock, 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Idle length: mostly none or short, a few long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sched_req_t make_req(logic [lrqs_pkg::MODE_W-1:0] mode,
                                          logic [lrqs_pkg::TASK_W-1:0] tid,
                                          logic [lrqs_pkg::LEVEL_W-1:0] level,
                                          logic [lrqs_pkg::COUNT_W-1:0] cnt);
    sched_req_t r;
    r.mode = mode;
    r.tid = tid;
    r.level = level;
    r.random_count = cnt;
    return r;
  endfunction

  // Residue that lands inside the ticket window of a level.
  function automatic int unsigned window_draw(int unsigned lvl);
    case (lvl)
      1: return $urandom_range(1, 10);
      2: return $urandom_range(12, 22);
      3: return $urandom_range(24, 36);
      4: return $urandom_range(38, 52);
      default: return $urandom_range(54, 71);
    endcase
  endfunction

  // Random item: mostly well-formed operations on the current queue contents.
  function automatic sched_req_t random_request();
    sched_req_t r;
    logic [lrqs_pkg::TASK_W-1:0] queued [$];
    logic [lrqs_pkg::TASK_W-1:0] idle_tasks [$];
    int unsigned nonempty [$];
    int unsigned pick;
    int unsigned lvl;
    int unsigned residue;
    logic [lrqs_pkg::TASK_W-1:0] t;
    r = make_req(lrqs_pkg::MODE_QUERY, lrqs_pkg::TASK_W'($urandom),
                 lrqs_pkg::LEVEL_W'($urandom), $urandom);
    for (int i = 0; i < NTASK; i++) begin
      if (tracker.level_of[i] != 0) queued.push_back(lrqs_pkg::TASK_W'(i));
      else idle_tasks.push_back(lrqs_pkg::TASK_W'(i));
    end
    for (int l = 0; l < lrqs_pkg::NUM_LEVELS; l++)
      if (tracker.ready_q[l].size() != 0) nonempty.push_back(l + 1);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.mode = lrqs_pkg::MODE_PUSH;
      if (idle_tasks.size() != 0 && $urandom_range(0, 99) < 85)
        r.tid = idle_tasks[$urandom_range(0, idle_tasks.size() - 1)];
      if ($urandom_range(0, 99) < 92)
        r.level = lrqs_pkg::LEVEL_W'($urandom_range(1, lrqs_pkg::NUM_LEVELS));
    end else if (pick < 60) begin
      r.mode = lrqs_pkg::MODE_DEQ;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if (nonempty.size() != 0) lvl = nonempty[$urandom_range(0, nonempty.size() - 1)];
        else lvl = $urandom_range(1, lrqs_pkg::NUM_LEVELS);
        residue = window_draw(lvl);
        r.random_count = 32'($urandom_range(0, 59652322)) * 32'(lrqs_pkg::TICKETS)
                         + 32'(residue);
      end else if (pick < 75) begin
        case ($urandom_range(0, 4))
          0: residue = 0;
          1: residue = 11;
          2: residue = 23;
          3: residue = 37;
          default: residue = 53;
        endcase
        r.random_count = 32'($urandom_range(0, 59652322)) * 32'(lrqs_pkg::TICKETS)
                         + 32'(residue);
      end
    end else if (pick < 80) begin
      r.mode = lrqs_pkg::MODE_REMOVE;
      if (queued.size() != 0 && $urandom_range(0, 99) < 80) begin
        t = queued[$urandom_range(0, queued.size() - 1)];
        r.tid = t;
        r.level = tracker.level_of[t];
      end
    end else begin
      r.mode = lrqs_pkg::MODE_QUERY;
      if (queued.size() != 0 && $urandom_range(0, 99) < 50) begin
        t = queued[$urandom_range(0, queued.size() - 1)];
        r.tid = t;
        r.level = tracker.level_of[t];
      end
    end
    return r;
  endfunction

  // Drives one item from a falling edge and returns at the falling edge after acceptance.
  task automatic send_request(sched_req_t r, bit calm);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= r.mode;
    in_ch.task_id      <= r.tid;
    in_ch.level        <= r.level;
    in_ch.random_count <= r.random_count;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.note_request(r);
    @(negedge clk);
  endtask

  // Holds the request channel idle until every owed result has come back.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result-side ready: random stalls, with a long stretch of steady ready now and then.
  initial begin
    out_ch.ready = 1'b0;
    rx_cycle = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if ((rx_cycle % 1500) < 200) begin
        out_ch.ready <= 1'b1;
        hold_left = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (out_ch.ready === 1'b1) begin
        hold_left = idle_len();
        if (hold_left > 0) begin
          out_ch.ready <= 1'b0;
          hold_left--;
        end
      end else begin
        out_ch.ready <= 1'b1;
        hold_left = $urandom_range(0, 5);
      end
    end
  end

  // Result monitor: every accepted result item is checked in order.
  initial begin
    sched_res_t got;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.status          = out_ch.status;
        got.chosen_task     = out_ch.chosen_task;
        got.found           = out_ch.found;
        got.successor_valid = out_ch.successor_valid;
        got.successor_task  = out_ch.successor_task;
        got.nonempty_mask   = out_ch.nonempty_mask;
        tracker.check_result(got);
      end
    end
  end

  // Main sequence: reset, directed items, random items, drain and verdict.
  initial begin
    int unsigned drain_cycles;
    tracker = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = lrqs_pkg::MODE_PUSH;
    in_ch.task_id = '0;
    in_ch.level = '0;
    in_ch.random_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bad levels, then a draw into an empty queue.
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd1, 3'd7, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_QUERY, 4'd1, 3'd6, 32'hFFFF_FFFF), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_REMOVE, 4'd1, 3'd0, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd0, 32'd5), 1'b0);
    // Three tasks on level 1, a double push, a query hit.
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd3, 3'd1, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd5, 3'd1, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd15, 3'd1, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd3, 3'd4, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_QUERY, 4'd5, 3'd1, 32'd0), 1'b0);
    // Middle removal, removal of an absent task, tail removal.
    send_request(make_req(lrqs_pkg::MODE_REMOVE, 4'd5, 3'd1, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_REMOVE, 4'd5, 3'd1, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_REMOVE, 4'd15, 3'd1, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd8, 3'd2, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd10, 3'd4, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_PUSH, 4'd12, 3'd5, 32'd0), 1'b0);
    // Draws between the windows miss even with queues filled.
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd1, 32'd0), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd1, 32'd72011), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd1, 32'd23), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd1, 32'd37), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd1, 32'd53), 1'b0);
    // Window edges and the all-ones count, which reduces to 39.
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd0, 32'd10), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd0, 32'hFFFF_FFFF), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd0, 32'd12), 1'b0);
    send_request(make_req(lrqs_pkg::MODE_DEQ, 4'd0, 3'd0, 32'd71), 1'b0);
    pause_until_drained();

    // Random part, with a steady stretch and a full drain now and then.
    for (int i = 0; i < 1000; i++) begin
      send_request(random_request(), (i % 200) >= 100 && (i % 200) < 140);
      if (i % 250 == 249) pause_until_drained();
    end
    in_ch.valid <= 1'b0;

    drain_cycles = 0;
    while (tracker.owed_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (tracker.owed_results.size() != 0)
      tracker.report_mismatch($sformatf("%0d result items never arrived",
                                        tracker.owed_results.size()));
    if (tracker.errors == 0) begin
      $display("lottery_ready_queue_scheduler regression: pass");
    end else begin
      $display("lottery_ready_queue_scheduler regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("lottery_ready_queue_scheduler regression: fail");
    $finish;
  end

endmodule
